// ----- rtl/midpoint_circle_point_generator_assert.svh -----
// Assertion macros for the midpoint circle point generator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef MIDPOINT_CIRCLE_POINT_GENERATOR_ASSERT_SVH
`define MIDPOINT_CIRCLE_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MCPG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mcpg assertion failed");

// next-cycle implication
`define MCPG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mcpg assertion failed");

`endif

// ----- rtl/mcpg_pkg.sv -----
// Package for the midpoint circle point generator: widths, codes, step descriptor.
// No dependencies.
`default_nettype none
package mcpg_pkg;
	localparam int COORD_BITS  = 12;
	localparam int RADIUS_BITS = 11;
	localparam int PT_BITS     = COORD_BITS + 2;
	localparam int DEC_BITS    = RADIUS_BITS + 4;
	localparam int IN_DATA_W   = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((2 * PT_BITS + 7) / 8) * 8;
	localparam int FIFO_DEPTH  = 2;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

	typedef struct packed {
		logic [COORD_BITS-1:0]  cx;
		logic [COORD_BITS-1:0]  cy;
		logic [RADIUS_BITS-1:0] ox;
		logic [RADIUS_BITS-1:0] oy;
		logic                   done;
	} step_t;
endpackage
`default_nettype wire

// ----- rtl/mcpg_front.sv -----
// Front end: accepts requests, keeps circle state, runs the decision update.
// Pushes one step descriptor per advance on a running circle. Depends on mcpg_pkg.
`default_nettype none
module mcpg_front (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire                            req_type,
	input  wire [mcpg_pkg::COORD_BITS-1:0]  center_x,
	input  wire [mcpg_pkg::COORD_BITS-1:0]  center_y,
	input  wire [mcpg_pkg::RADIUS_BITS-1:0] radius,
	output logic                           push,
	output mcpg_pkg::step_t                push_data,
	input  wire                            full
);
	import mcpg_pkg::*;

	localparam int SW = DEC_BITS + 1;
	localparam logic signed [SW-1:0] K3  = SW'(3);
	localparam logic signed [SW-1:0] K6  = SW'(6);
	localparam logic signed [SW-1:0] K10 = SW'(10);

	logic [COORD_BITS-1:0]  cx_q, cy_q;
	logic [RADIUS_BITS-1:0] ox_q, oy_q;
	logic [DEC_BITS-1:0]    dec_q;
	logic                   active_q;

	logic                   accept;
	logic signed [SW-1:0]   xs, ys, rs, ds, dsum, dinit;
	logic [RADIUS_BITS-1:0] ox_nx, oy_nx;
	logic                   dec_neg;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		xs      = $signed({{(SW-RADIUS_BITS){1'b0}}, ox_q});
		ys      = $signed({{(SW-RADIUS_BITS){1'b0}}, oy_q});
		rs      = $signed({{(SW-RADIUS_BITS){1'b0}}, radius});
		ds      = $signed({dec_q[DEC_BITS-1], dec_q});
		dec_neg = dec_q[DEC_BITS-1];
		dinit   = K3 - (rs <<< 1);
		if (dec_neg) begin
			dsum  = ds + (xs <<< 2) + K6;
			oy_nx = oy_q;
		end else begin
			dsum  = ds + ((xs - ys) <<< 2) + K10;
			oy_nx = (oy_q != '0) ? oy_q - 1'b1 : oy_q;
		end
		ox_nx = ox_q + 1'b1;
	end

	assign push           = accept && (req_type == REQ_ADVANCE) && active_q;
	assign push_data.cx   = cx_q;
	assign push_data.cy   = cy_q;
	assign push_data.ox   = ox_q;
	assign push_data.oy   = oy_q;
	assign push_data.done = ox_nx > oy_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (req_type == REQ_START) begin
				cx_q     <= center_x;
				cy_q     <= center_y;
				ox_q     <= '0;
				oy_q     <= radius;
				dec_q    <= dinit[DEC_BITS-1:0];
				active_q <= 1'b1;
			end else if (active_q) begin
				ox_q     <= ox_nx;
				oy_q     <= oy_nx;
				dec_q    <= dsum[DEC_BITS-1:0];
				active_q <= !(ox_nx > oy_nx);
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/mcpg_fifo.sv -----
// Short step queue between front and back ends.
// Depends on mcpg_pkg.
`default_nettype none
module mcpg_fifo (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  mcpg_pkg::step_t push_data,
	output logic            full,
	input  wire             pop,
	output mcpg_pkg::step_t pop_data,
	output logic            empty
);
	import mcpg_pkg::*;

	step_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_PTR_W:0]   cnt_q;

	assign full     = cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/mcpg_back.sv -----
// Back end: expands one step descriptor into eight octant points.
// Registered output stage, one point per cycle while out_ready is high. Depends on mcpg_pkg.
`default_nettype none
module mcpg_back (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         empty,
	input  mcpg_pkg::step_t             head,
	output logic                        pop,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [mcpg_pkg::PT_BITS-1:0] point_x,
	output logic [mcpg_pkg::PT_BITS-1:0] point_y,
	output logic                        step_last,
	output logic                        circle_done
);
	import mcpg_pkg::*;

	step_t               cur_q;
	logic                busy_q;
	logic [2:0]          idx_q;
	logic                vld_q;
	logic [PT_BITS-1:0]  px_q, py_q;
	logic                last_q, done_q;

	logic                adv, at_end;
	logic [RADIUS_BITS-1:0] oa, ob;
	logic [PT_BITS-1:0]  cxe, cye, ae, be, px, py;

	assign adv    = busy_q && (!vld_q || out_ready);
	assign at_end = idx_q == 3'd7;
	assign pop    = !empty && (!busy_q || (adv && at_end));

	always_comb begin
		oa  = idx_q[2] ? cur_q.oy : cur_q.ox;
		ob  = idx_q[2] ? cur_q.ox : cur_q.oy;
		cxe = {{(PT_BITS-COORD_BITS){1'b0}}, cur_q.cx};
		cye = {{(PT_BITS-COORD_BITS){1'b0}}, cur_q.cy};
		ae  = {{(PT_BITS-RADIUS_BITS){1'b0}}, oa};
		be  = {{(PT_BITS-RADIUS_BITS){1'b0}}, ob};
		px  = idx_q[1] ? cxe - ae : cxe + ae;
		py  = idx_q[0] ? cye - be : cye + be;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q   <= px;
			py_q   <= py;
			last_q <= at_end;
			done_q <= at_end && cur_q.done;
		end
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			vld_q  <= 1'b0;
		end else begin
			if (adv) begin
				vld_q <= 1'b1;
				idx_q <= idx_q + 1'b1;
				if (at_end) begin
					busy_q <= 1'b0;
				end
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end
	end

	assign out_valid   = vld_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign step_last   = last_q;
	assign circle_done = done_q;
endmodule
`default_nettype wire

// ----- rtl/midpoint_circle_point_generator.sv -----
// Midpoint circle point generator, top level.
// Instantiates mcpg_front, mcpg_fifo and mcpg_back; depends on mcpg_pkg and the assert header.
//
// Usage:
//   Slave stream: s_tuser is the request kind (start or advance), s_tdata carries
//   centre and radius. A start loads a circle and yields no output. An advance on a
//   running circle yields eight points on the master stream; an advance with no
//   circle running yields nothing.
//   Master stream: m_tdata carries one point, m_tlast marks the eighth point of a
//   step, m_tuser marks the last point of the circle.
//   Path: an accepted advance passes through the step queue, the back end's step register
//   and its output register before m_tvalid rises.
//   Throughput: one point per cycle while m_tready is high; the back end emits one
//   point per cycle through its output register, eight points per advance.
//   The front end takes requests while the two-entry step queue has room, so starts
//   and advances keep flowing while points are being drained.
//   Stall: when m_tready is low the point holds; the queue fills and then s_tready
//   drops until the back end moves again.
//   Reset: arst_n clears all control state; no circle runs and no output is valid.
`default_nettype none
`include "midpoint_circle_point_generator_assert.svh"
module midpoint_circle_point_generator (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// center_x, center_y, radius, zero pad
	input  wire [mcpg_pkg::IN_DATA_W-1:0] s_tdata,
	// req_type
	input  wire                          s_tuser,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// point_x, point_y, zero pad
	output logic [mcpg_pkg::OUT_DATA_W-1:0] m_tdata,
	// circle_done
	output logic                         m_tuser,
	// step_last
	output logic                         m_tlast
);
	import mcpg_pkg::*;

	logic               push, pop, full, empty;
	step_t              push_data, head;
	logic [PT_BITS-1:0] point_x, point_y;

	mcpg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.req_type  (s_tuser),
		.center_x  (s_tdata[COORD_BITS-1:0]),
		.center_y  (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.radius    (s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	mcpg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	mcpg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.point_x     (point_x),
		.point_y     (point_y),
		.step_last   (m_tlast),
		.circle_done (m_tuser)
	);

	assign m_tdata = {{(OUT_DATA_W-2*PT_BITS){1'b0}}, point_y, point_x};

	`MCPG_ASSERT_IMP(a_done_is_last, m_tvalid && m_tuser, m_tlast)
	`MCPG_ASSERT_IMP(a_no_push_full, push, !full)
	`MCPG_ASSERT_IMP(a_no_pop_empty, pop, !empty)
	`MCPG_ASSERT_NXT(a_step_continues, m_tvalid && m_tready && !m_tlast, m_tvalid)
endmodule
`default_nettype wire
